// ===== rtl/core/i2c_master_bit_engine_macros.svh =====
// Assertion macros shared by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define I2CMBE_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define I2CMBE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2cmbe_pkg.sv =====
// Types and constants of the I2C master bit engine.
package i2cmbe_pkg;

  // Sequence currently running on the bus.
  typedef enum logic [2:0] {
    KIND_IDLE  = 3'd0,
    KIND_START = 3'd1,
    KIND_SEND  = 3'd2,
    KIND_READ  = 3'd3,
    KIND_STOP  = 3'd4
  } kind_t;

  // Command codes carried in the input beat.
  localparam logic [2:0] CMD_NONE        = 3'd0;
  localparam logic [2:0] CMD_START_WRITE = 3'd1;
  localparam logic [2:0] CMD_START_READ  = 3'd2;
  localparam logic [2:0] CMD_WRITE_BYTE  = 3'd3;
  localparam logic [2:0] CMD_READ_BYTE   = 3'd4;
  localparam logic [2:0] CMD_STOP        = 3'd5;

  // Phase numbers within a start, stop or bit.
  localparam logic [1:0] PHASE_SETUP = 2'd0;
  localparam logic [1:0] PHASE_HIGH  = 2'd1;
  localparam logic [1:0] PHASE_LOW   = 2'd2;

  // Index of the last data bit of a byte; the following bit is the acknowledge.
  localparam logic [3:0] MSB_INDEX = 4'd7;

  localparam int          DIVIDER_WIDTH_DEFAULT = 16;
  localparam logic [15:0] PHASE_TICKS_RESET     = 16'd100;

  // Register byte addresses.
  localparam logic [2:0] ADDR_PHASE_TICKS = 3'd0;

  // Bus levels driven by the engine.
  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } levels_t;

endpackage

// ===== rtl/core/i2c_master_bit_engine.sv =====
// I2C master bit engine: command sequencer with stream ports and an APB register.
// The result beat for an input beat is registered and appears on the master side
// in the cycle after the input beat is accepted.
// Throughput: one input beat per clock while no result is held back by m_tready;
// each beat is one bus tick, a single registered pass through the sequencer logic.
// Reset (rst, synchronous, active high): bus idle with SCL and SDA driven high,
// no sequence running, phase_ticks back to 100 and no result beat pending.
module i2c_master_bit_engine #(
  parameter int DIVIDER_WIDTH = i2cmbe_pkg::DIVIDER_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream. s_tdata, from bit 0: cmd[2:0], target_address[9:3],
  // write_data[17:10], last_byte[18], sda_in[19], zero padding[23:20].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  // Result stream. m_tdata, from bit 0: scl_out[0], sda_out[1], sda_enable[2],
  // busy_res[3], done_res[4], ack_error[5], read_valid[6], read_data[14:7],
  // rejected[15].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import i2cmbe_pkg::*;

  `include "i2c_master_bit_engine_macros.svh"

  localparam int LEN_BITS = (DIVIDER_WIDTH < 16) ? DIVIDER_WIDTH : 16;
  localparam int CMP_BITS = DIVIDER_WIDTH + 1;

  // ---------------------------------------------------------------------------
  // Configuration register. Only bit 2 of the address selects a register, so
  // byte offsets 0 to 3 all reach phase_ticks.
  // ---------------------------------------------------------------------------
  logic [15:0] phase_ticks;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_PHASE_TICKS[2]);
  assign prdata    = (paddr[2] == ADDR_PHASE_TICKS[2]) ? {16'b0, phase_ticks} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_write) begin
      phase_ticks <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state. Every accepted beat is one bus tick.
  // ---------------------------------------------------------------------------
  kind_t                    kind, kind_next;
  logic [1:0]               phase_index, phase_index_next;
  logic [3:0]               bit_index, bit_index_next;
  logic [7:0]               shift_byte, shift_byte_next;
  logic [DIVIDER_WIDTH-1:0] tick_count, tick_count_next;
  logic                     ack_level, ack_level_next;
  logic                     scl_level, scl_level_next;
  logic                     sda_level, sda_level_next;
  logic                     sda_drive, sda_drive_next;

  // Unpacked input beat.
  logic [2:0] cmd;
  logic [6:0] target_address;
  logic [7:0] write_data;
  logic       last_byte;
  logic       sda_in;

  assign cmd            = s_tdata[2:0];
  assign target_address = s_tdata[9:3];
  assign write_data     = s_tdata[17:10];
  assign last_byte      = s_tdata[18];
  assign sda_in         = s_tdata[19];

  // Phase length: the register cut to the divider width, with zero counting as one.
  logic [DIVIDER_WIDTH-1:0] len_masked;
  logic [DIVIDER_WIDTH-1:0] len_eff;
  logic                     phase_end;

  assign len_masked = DIVIDER_WIDTH'(phase_ticks[LEN_BITS-1:0]);
  assign len_eff    = (len_masked == '0) ? DIVIDER_WIDTH'(1) : len_masked;
  assign phase_end  = ({1'b0, tick_count} + CMP_BITS'(1)) >= {1'b0, len_eff};

  // A bit is driven by the master for data bits of a write and for the
  // acknowledge bit of a read; otherwise SDA is released.
  function automatic logic bit_is_sent(input kind_t k, input logic [3:0] b);
    logic sent;
    if (k == KIND_SEND) begin
      sent = (b <= MSB_INDEX);
    end else begin
      sent = (b > MSB_INDEX);
    end
    return sent;
  endfunction

  // Levels on entry to a phase, following the start, stop and bit waveforms.
  function automatic levels_t enter_phase(input kind_t k, input logic [1:0] p,
                                          input logic [3:0] b, input logic [7:0] sh,
                                          input logic ack, input levels_t cur);
    levels_t lv;
    lv = cur;
    unique case (k)
      KIND_START: begin
        if (p == PHASE_SETUP) begin
          lv.drv = 1'b1;
          lv.sda = 1'b1;
          lv.scl = 1'b1;
        end else if (p == PHASE_HIGH) begin
          lv.sda = 1'b0;
        end else begin
          lv.scl = 1'b0;
        end
      end
      KIND_STOP: begin
        if (p == PHASE_SETUP) begin
          lv.drv = 1'b1;
          lv.sda = 1'b0;
          lv.scl = 1'b0;
        end else if (p == PHASE_HIGH) begin
          lv.scl = 1'b1;
        end else begin
          lv.sda = 1'b1;
        end
      end
      KIND_SEND, KIND_READ: begin
        if (p == PHASE_SETUP) begin
          if (bit_is_sent(k, b)) begin
            lv.drv = 1'b1;
            lv.sda = (k == KIND_SEND) ? sh[7] : ack;
          end else begin
            lv.drv = 1'b0;
          end
        end else if (p == PHASE_HIGH) begin
          lv.scl = 1'b1;
        end else begin
          lv.scl = 1'b0;
        end
      end
      default: lv = cur;
    endcase
    return lv;
  endfunction

  // Result fields of the current tick.
  logic       busy_res;
  logic       done_res;
  logic       ack_error;
  logic       read_valid;
  logic [7:0] read_data;
  logic       rejected;
  logic       valid_cmd;
  levels_t    lv;

  assign busy_res  = (kind != KIND_IDLE);
  assign valid_cmd = (cmd == CMD_START_WRITE) || (cmd == CMD_START_READ) ||
                     (cmd == CMD_WRITE_BYTE) || (cmd == CMD_READ_BYTE) ||
                     (cmd == CMD_STOP);

  always_comb begin
    kind_next        = kind;
    phase_index_next = phase_index;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    tick_count_next  = tick_count;
    ack_level_next   = ack_level;
    lv               = '{scl: scl_level, sda: sda_level, drv: sda_drive};
    done_res         = 1'b0;
    ack_error        = 1'b0;
    read_valid       = 1'b0;
    read_data        = 8'd0;
    rejected         = 1'b0;

    if (busy_res) begin
      rejected = valid_cmd;
      if (!phase_end) begin
        tick_count_next = tick_count + DIVIDER_WIDTH'(1);
      end else begin
        tick_count_next = '0;
        // SDA is sampled at the end of the SCL-high phase of a bit the slave drives.
        if (phase_index == PHASE_HIGH && (kind == KIND_SEND || kind == KIND_READ) &&
            !bit_is_sent(kind, bit_index)) begin
          if (kind == KIND_READ) begin
            shift_byte_next = {shift_byte[6:0], sda_in};
          end else begin
            ack_level_next = sda_in;
          end
        end
        if (phase_index < PHASE_LOW) begin
          phase_index_next = phase_index + 2'd1;
          lv = enter_phase(kind, phase_index_next, bit_index, shift_byte_next,
                           ack_level_next, lv);
        end else if (kind == KIND_START) begin
          // The address byte follows the start condition directly.
          kind_next        = KIND_SEND;
          phase_index_next = PHASE_SETUP;
          bit_index_next   = 4'd0;
          lv = enter_phase(KIND_SEND, PHASE_SETUP, 4'd0, shift_byte_next,
                           ack_level_next, lv);
        end else if (kind == KIND_STOP) begin
          done_res         = 1'b1;
          kind_next        = KIND_IDLE;
          phase_index_next = PHASE_SETUP;
        end else begin
          if (kind == KIND_SEND && bit_index <= MSB_INDEX) begin
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
          end
          if (bit_index <= MSB_INDEX) begin
            bit_index_next   = bit_index + 4'd1;
            phase_index_next = PHASE_SETUP;
            lv = enter_phase(kind, PHASE_SETUP, bit_index_next, shift_byte_next,
                             ack_level_next, lv);
          end else if (kind == KIND_SEND) begin
            if (ack_level_next) begin
              // Not acknowledged: flag it and release the bus with a stop.
              ack_error        = 1'b1;
              kind_next        = KIND_STOP;
              phase_index_next = PHASE_SETUP;
              bit_index_next   = 4'd0;
              lv = enter_phase(KIND_STOP, PHASE_SETUP, 4'd0, shift_byte_next,
                               ack_level_next, lv);
            end else begin
              done_res         = 1'b1;
              kind_next        = KIND_IDLE;
              phase_index_next = PHASE_SETUP;
              bit_index_next   = 4'd0;
            end
          end else begin
            done_res         = 1'b1;
            read_valid       = 1'b1;
            read_data        = shift_byte_next;
            kind_next        = KIND_IDLE;
            phase_index_next = PHASE_SETUP;
            bit_index_next   = 4'd0;
          end
        end
      end
    end else if (valid_cmd) begin
      kind_next        = KIND_IDLE;
      phase_index_next = PHASE_SETUP;
      bit_index_next   = 4'd0;
      tick_count_next  = '0;
      unique case (cmd)
        CMD_START_WRITE, CMD_START_READ: begin
          shift_byte_next = {target_address, (cmd == CMD_START_READ)};
          kind_next       = KIND_START;
        end
        CMD_WRITE_BYTE: begin
          shift_byte_next = write_data;
          kind_next       = KIND_SEND;
        end
        CMD_READ_BYTE: begin
          shift_byte_next = 8'd0;
          ack_level_next  = last_byte;
          kind_next       = KIND_READ;
        end
        default: begin
          kind_next = KIND_STOP;
        end
      endcase
      lv = enter_phase(kind_next, PHASE_SETUP, 4'd0, shift_byte_next, ack_level_next, lv);
    end

    scl_level_next = lv.scl;
    sda_level_next = lv.sda;
    sda_drive_next = lv.drv;
  end

  // ---------------------------------------------------------------------------
  // Handshake. The result register parts the two sides: a new beat is taken
  // whenever the register is empty or its beat leaves in this cycle.
  // ---------------------------------------------------------------------------
  logic accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind        <= KIND_IDLE;
      phase_index <= PHASE_SETUP;
      bit_index   <= 4'd0;
      shift_byte  <= 8'd0;
      tick_count  <= '0;
      ack_level   <= 1'b0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      sda_drive   <= 1'b1;
    end else if (accept) begin
      kind        <= kind_next;
      phase_index <= phase_index_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      tick_count  <= tick_count_next;
      ack_level   <= ack_level_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      sda_drive   <= sda_drive_next;
    end
  end

  // The result beat reports the levels held during the tick, not the next ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {rejected, read_data, read_valid, ack_error, done_res, busy_res,
                  sda_drive, sda_drive & sda_level, scl_level};
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `I2CMBE_ASSERT_NOW(a_phase_range, clk, rst, 1'b1, phase_index != 2'd3,
                     "phase index out of range")
  `I2CMBE_ASSERT_NOW(a_tick_bound, clk, rst, busy_res, tick_count < len_eff,
                     "tick counter ran past the phase length")
  `I2CMBE_ASSERT_NOW(a_done_excl, clk, rst, accept, !(done_res && ack_error),
                     "done and acknowledge error in the same tick")
  `I2CMBE_ASSERT_NEXT(a_stop_ends, clk, rst,
                      accept && kind == KIND_STOP && phase_end && phase_index == PHASE_LOW,
                      kind == KIND_IDLE && scl_level && sda_level && sda_drive,
                      "stop did not leave the bus idle")
endmodule
